// ===== rtl/core/novelty_diversity_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// novelty diversity buffer assertion macros
// shared property wrappers used by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef NOVELTY_DIVERSITY_BUFFER_DEFINES_SVH
`define NOVELTY_DIVERSITY_BUFFER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define NDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NDB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ndb_pkg.sv =====
// ----------------------------------------------------------------------------
// ndb_pkg
// sizes, codes and shared types of the novelty diversity buffer
// ----------------------------------------------------------------------------
package ndb_pkg;

    localparam int VECTOR_LEN  = 45;
    localparam int BUFFER_SIZE = 32;

    localparam int VALUE_W    = 16;
    localparam int DIST_W     = 38;
    localparam int MINF_W     = 6;
    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 5;
    localparam int FILLCNT_W  = 6;
    localparam int CFG_IDX_W  = 1;

    localparam int POS_W      = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int IDX_W      = $clog2(BUFFER_SIZE);
    localparam int FILL_W     = $clog2(BUFFER_SIZE + 1);
    localparam int ENT_AW     = IDX_W + POS_W;
    localparam int ENT_DEPTH  = 1 << ENT_AW;
    localparam int SQ_W       = 2 * VALUE_W + 2;
    localparam int CNT_CMP_W  = (FILL_W > MINF_W) ? FILL_W : MINF_W;

    localparam logic [DIST_W-1:0] SAT_DIST        = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(65536);
    localparam logic [MINF_W-1:0] MIN_FILL_RESET  = MINF_W'(4);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD_SQ = 1'b0;
    localparam t_cfg_idx CFG_MIN_FILL     = 1'b1;

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_DISCARD = 2'd0;
    localparam t_action ACT_APPEND  = 2'd1;
    localparam t_action ACT_REPLACE = 2'd2;

    typedef struct packed {
        logic                      command;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_action               action;
        logic [SLOT_W-1:0]     slot;
        logic [FILLCNT_W-1:0]  fill_count;
        logic [DIST_W-1:0]     nearest_dist_sq;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept_elem;
        logic accept_clear;
        logic scan_issue;
        logic decide;
        logic copy_issue;
        logic post;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic pos_last;
        logic cur_last;
        logic scan_last;
        logic pipe_busy;
        logic copy_last;
        logic do_write;
    } t_dp_sts;

endpackage

// ===== rtl/core/ndb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ndb_ctrl
// sequencer: element and clear intake, distance scan, decision, entry copy, result post
// ----------------------------------------------------------------------------
`include "novelty_diversity_buffer_defines.svh"

module ndb_ctrl import ndb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_command,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_DECIDE = 6'b001000,
        S_COPY   = 6'b010000,
        S_POST   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == CMD_CLEAR) begin
                        o_cmd.accept_clear = 1'b1;
                    end else begin
                        o_cmd.accept_elem = 1'b1;
                        if (!i_sts.fill_zero) begin
                            n_state = S_SCAN;
                        end else if (i_sts.pos_last) begin
                            n_state = S_DECIDE;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = i_sts.cur_last ? S_DECIDE : S_IDLE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.do_write ? S_COPY : S_POST;
            end
            S_COPY: begin
                o_cmd.copy_issue = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    o_cmd.post  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `NDB_ASSERT_IMP(a_post_needs_room, i_clk, i_rst_n, o_cmd.post, !r_out_valid || i_out_ready, "result posted over a pending result")
    `NDB_ASSERT_NXT(a_discard_skips_copy, i_clk, i_rst_n, r_state == S_DECIDE && !i_sts.do_write, r_state == S_POST, "discard went through copy")
    `NDB_ASSERT_IMP(a_scan_needs_entries, i_clk, i_rst_n, r_state == S_SCAN, !i_sts.fill_zero, "scan with empty buffer")

endmodule

// ===== rtl/core/ndb_datapath.sv =====
// ----------------------------------------------------------------------------
// ndb_datapath
// entry store, staging memory, shared squared-distance mac and decision
// ----------------------------------------------------------------------------
`include "novelty_diversity_buffer_defines.svh"

module ndb_datapath import ndb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_cfg_valid,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [DIST_W-1:0]         i_cfg_data,
    output t_out_item                 o_out_data
);

    // configuration
    logic [DIST_W-1:0] r_thr;
    logic [MINF_W-1:0] r_min_fill;

    // control counters
    logic [FILL_W-1:0] r_fill;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_cur_pos;
    logic              r_cur_last;
    logic [FILL_W-1:0] r_j;
    logic [POS_W-1:0]  r_k;

    // scan pipeline
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_s1_v, r_s2_v;
    logic [IDX_W-1:0]          r_s1_j, r_s2_j;
    logic signed [VALUE_W-1:0] r_ent_q;
    logic [DIST_W-1:0]         r_acc_q;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_acc_in;
    logic [DIST_W-1:0]         r_best;
    logic [IDX_W-1:0]          r_best_idx;

    // copy path
    logic                      r_cp_v;
    logic [POS_W-1:0]          r_cp_k;
    logic signed [VALUE_W-1:0] r_stg_q;
    logic [IDX_W-1:0]          r_wslot;

    t_out_item r_res, r_out;

    // memories
    logic signed [VALUE_W-1:0] r_entry_mem [ENT_DEPTH];
    logic signed [VALUE_W-1:0] r_stg_mem [VECTOR_LEN];
    logic [DIST_W-1:0]         r_acc_mem [BUFFER_SIZE];

    logic                      pos_last;
    logic signed [VALUE_W:0]   diff;
    logic signed [SQ_W-1:0]    prod;
    logic [DIST_W:0]           sum;
    logic [DIST_W-1:0]         acc_new;
    logic                      room, uncond, below;
    t_action                   dec_act;
    logic [IDX_W-1:0]          dec_slot;
    logic [FILL_W-1:0]         fill_next;
    t_out_item                 dec_res;

    assign pos_last = (r_pos == POS_W'(VECTOR_LEN - 1));

    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.pos_last  = pos_last;
    assign o_sts.cur_last  = r_cur_last;
    assign o_sts.scan_last = ((r_j + FILL_W'(1)) == r_fill);
    assign o_sts.pipe_busy = r_s1_v || r_s2_v;
    assign o_sts.copy_last = (r_k == POS_W'(VECTOR_LEN - 1));
    assign o_sts.do_write  = (dec_act != ACT_DISCARD);

    assign o_out_data = r_out;

    // mac: difference, square, accumulate with saturation
    assign diff = $signed({r_value[VALUE_W-1], r_value}) - $signed({r_ent_q[VALUE_W-1], r_ent_q});
    assign prod = diff * diff;
    assign sum  = {1'b0, r_acc_in} + (DIST_W + 1)'(r_sq);
    assign acc_new = sum[DIST_W] ? SAT_DIST : sum[DIST_W-1:0];

    // decision for a completed vector
    always_comb begin
        room   = (r_fill < FILL_W'(BUFFER_SIZE));
        uncond = (r_fill == '0)
              || ((CNT_CMP_W'(r_fill) < CNT_CMP_W'(r_min_fill)) && room);
        below  = (r_best < r_thr);
        if (uncond) begin
            dec_act = ACT_APPEND;
        end else if (below) begin
            dec_act = ACT_DISCARD;
        end else if (room) begin
            dec_act = ACT_APPEND;
        end else begin
            dec_act = ACT_REPLACE;
        end
        dec_slot  = (dec_act == ACT_APPEND) ? r_fill[IDX_W-1:0] : r_best_idx;
        fill_next = (dec_act == ACT_APPEND) ? (r_fill + FILL_W'(1)) : r_fill;
        dec_res.action          = dec_act;
        dec_res.slot            = SLOT_W'(dec_slot);
        dec_res.fill_count      = FILLCNT_W'(fill_next);
        dec_res.nearest_dist_sq = uncond ? '0 : r_best;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THRESHOLD_RESET;
            r_min_fill <= MIN_FILL_RESET;
            r_fill     <= '0;
            r_pos      <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_cp_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD_SQ: r_thr <= i_cfg_data;
                    CFG_MIN_FILL:     r_min_fill <= i_cfg_data[MINF_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept_clear) begin
                r_fill <= '0;
                r_pos  <= '0;
            end
            if (i_cmd.accept_elem) begin
                r_pos <= pos_last ? '0 : (r_pos + POS_W'(1));
            end
            if (i_cmd.decide) begin
                r_fill <= fill_next;
            end
            r_s1_v <= i_cmd.scan_issue;
            r_s2_v <= r_s1_v;
            r_cp_v <= i_cmd.copy_issue;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_elem) begin
            r_value    <= i_value;
            r_cur_pos  <= r_pos;
            r_cur_last <= pos_last;
            r_j        <= '0;
        end else if (i_cmd.scan_issue) begin
            r_j <= r_j + FILL_W'(1);
        end
        r_s1_j   <= r_j[IDX_W-1:0];
        r_s2_j   <= r_s1_j;
        r_sq     <= prod;
        r_acc_in <= (r_cur_pos == '0) ? '0 : r_acc_q;
        // running minimum on the last element, lowest index wins ties
        if (r_s2_v && r_cur_last) begin
            if (r_s2_j == '0 || acc_new < r_best) begin
                r_best     <= acc_new;
                r_best_idx <= r_s2_j;
            end
        end
        if (i_cmd.decide) begin
            r_res   <= dec_res;
            r_wslot <= dec_slot;
            r_k     <= '0;
        end else if (i_cmd.copy_issue) begin
            r_k <= r_k + POS_W'(1);
        end
        r_cp_k <= r_k;
        if (i_cmd.post) begin
            r_out <= r_res;
        end
    end

    // entry store: scan reads, copy writes
    always_ff @(posedge i_clk) begin
        if (r_cp_v) begin
            r_entry_mem[{r_wslot, r_cp_k}] <= r_stg_q;
        end
        r_ent_q <= r_entry_mem[{r_j[IDX_W-1:0], r_cur_pos}];
    end

    // staging memory for the incoming vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_elem) begin
            r_stg_mem[r_pos] <= i_value;
        end
        r_stg_q <= r_stg_mem[r_k];
    end

    // per-entry distance accumulators
    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc_mem[r_s2_j] <= acc_new;
        end
        r_acc_q <= r_acc_mem[r_j[IDX_W-1:0]];
    end

    `NDB_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(BUFFER_SIZE), "fill count beyond buffer size")
    `NDB_ASSERT_IMP(a_replace_when_full, i_clk, i_rst_n, i_cmd.decide && dec_act == ACT_REPLACE, r_fill == FILL_W'(BUFFER_SIZE), "replace while buffer has room")
    `NDB_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, i_cmd.accept_clear, r_fill == '0, "clear left entries")

endmodule

// ===== rtl/core/novelty_diversity_buffer.sv =====
// ----------------------------------------------------------------------------
// novelty_diversity_buffer
// streaming novelty filter over a buffer of stored feature vectors
// ----------------------------------------------------------------------------
// Elements of a feature vector arrive one per request. Each element is accepted
// in the idle state and, when the buffer holds entries, is then scanned through
// the single shared squared-difference multiply-accumulate, which walks the
// stored entries one per cycle, and drained from its pipeline before the next
// element is accepted. The last element of a vector then takes a decision step,
// a copy of the staged vector into the entry store when it is appended or
// replaces an entry (one element per cycle through the store's write port),
// and a result post; posting waits only if the previous result has not been
// taken. A clear request is taken in the idle state. There is no clearing
// pass after reset.

module novelty_diversity_buffer import ndb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_item         o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [DIST_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ndb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_command (i_data.command),
        .o_in_ready   (o_ready),
        .o_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    ndb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_data.value),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_data)
    );

endmodule
